// ===== rtl/lrwf_pkg.sv =====
package lrwf_pkg;

    // item modes
    localparam logic [1:0] MODE_ROW_START = 2'd0;
    localparam logic [1:0] MODE_FB_BYTE   = 2'd1;
    localparam logic [1:0] MODE_MONO_BYTE = 2'd2;

    // panel command codes
    localparam logic [15:0] CMD_ADDR_SET = 16'h0011;
    localparam logic [15:0] CMD_RAM_DATA = 16'h0012;

    // configuration register indexes
    localparam logic CFG_FLIP = 1'b0;
    localparam logic CFG_MINI = 1'b1;

    // byte pairing phase
    typedef enum logic [1:0] {
        PH_AWAIT   = 2'd0,
        PH_PRIMED  = 2'd1,
        PH_PENDING = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic        is_command;
        logic [15:0] bus_value;
        logic        last;
    } t_xfer;

    // double each bit of a nibble into a dibit
    function automatic logic [7:0] dibit_double(input logic [3:0] nib);
        logic [7:0] res;
        case (nib)
            4'h0: res = 8'h00;
            4'h1: res = 8'h03;
            4'h2: res = 8'h0C;
            4'h3: res = 8'h0F;
            4'h4: res = 8'h30;
            4'h5: res = 8'h33;
            4'h6: res = 8'h3C;
            4'h7: res = 8'h3F;
            4'h8: res = 8'hC0;
            4'h9: res = 8'hC3;
            4'hA: res = 8'hCC;
            4'hB: res = 8'hCF;
            4'hC: res = 8'hF0;
            4'hD: res = 8'hF3;
            4'hE: res = 8'hFC;
            default: res = 8'hFF;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/lrwf_in_if.sv =====
interface lrwf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] row;
    logic [4:0] column_word;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output row, output column_word,
                    output data_byte, input ready);
    modport sink   (input valid, input mode, input row, input column_word,
                    input data_byte, output ready);
endinterface

// ===== rtl/lrwf_out_if.sv =====
interface lrwf_out_if;
    logic        valid;
    logic        ready;
    logic        is_command;
    logic [15:0] bus_value;
    logic        last;

    modport source (output valid, output is_command, output bus_value, output last,
                    input ready);
    modport sink   (input valid, input is_command, input bus_value, input last,
                    output ready);
endinterface

// ===== rtl/lcd_row_write_formatter.sv =====
// Channel    Dir  Payload                              Request per
// ---------  ---  -----------------------------------  ------------------------
// i_req      in   mode, row, column_word, data_byte    one item
// o_res      out  is_command, bus_value, last          one bus transfer
// i_cfg_*    in   index (flip, mini_panel), 1-bit data one register write
//
// Items are registered from the input register into the result buffer; byte
// items move every cycle while the sink is ready, a row start holds the input
// register while its three transfers drain from the result buffer.
// Reset (synchronous, active low) empties both stages and clears the pairing
// state and configuration. The input register takes a new request while a
// result still waits, so a stalled sink backs up only after one held item.
module lcd_row_write_formatter #(
    parameter int PIXEL_COLUMNS = 168
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrwf_in_if.sink       i_req,
    lrwf_out_if.source    o_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic          i_cfg_data
);
    import lrwf_pkg::*;

    localparam int LASTWORD      = PIXEL_COLUMNS / 8 - 1;
    localparam int FLIP_BASE     = 4 << 5;
    localparam int MINI_BASE     = 22 << 5;
    localparam logic [15:0] OFS_PLAIN = 16'(LASTWORD);
    localparam logic [15:0] OFS_FLIP  = 16'(FLIP_BASE + LASTWORD - 1);
    localparam logic [15:0] OFS_MINI  = 16'(MINI_BASE + LASTWORD - 4);

    logic        r_flip;
    logic        r_mini;

    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic [6:0]  r_in_row;
    logic [4:0]  r_in_col;
    logic [7:0]  r_in_byte;

    logic [7:0]  r_pending;
    logic [7:0]  r_window;
    t_phase      r_phase;

    t_xfer       r_buf [3];
    logic [1:0]  r_left;
    logic [1:0]  r_pos;

    t_xfer       n_buf [3];
    logic [1:0]  n_cnt;
    logic [7:0]  n_pending;
    logic [7:0]  n_window;
    t_phase      n_phase;

    logic        in_fire;
    logic        out_fire;
    logic        move;
    logic [15:0] offset;
    logic [15:0] addr;

    assign out_fire = o_res.valid && o_res.ready;
    // hand the held item on once the buffer is empty or draining its last entry
    assign move     = r_in_valid && ((r_left == 2'd0) || ((r_left == 2'd1) && o_res.ready));
    assign i_req.ready = !r_in_valid || move;
    assign in_fire  = i_req.valid && i_req.ready;

    assign o_res.valid      = (r_left != 2'd0);
    assign o_res.is_command = r_buf[r_pos].is_command;
    assign o_res.bus_value  = r_buf[r_pos].bus_value;
    assign o_res.last       = r_buf[r_pos].last;

    always_comb begin
        if (!r_flip) begin
            offset = OFS_PLAIN;
        end else if (r_mini) begin
            offset = OFS_MINI;
        end else begin
            offset = OFS_FLIP;
        end
        addr = {4'b0, r_in_row, 5'b0} + offset - {11'b0, r_in_col};
    end

    always_comb begin
        n_buf[0]  = '0;
        n_buf[1]  = '0;
        n_buf[2]  = '0;
        n_cnt     = 2'd0;
        n_pending = r_pending;
        n_window  = r_window;
        n_phase   = r_phase;
        case (r_in_mode)
            MODE_ROW_START: begin
                n_buf[0] = '{is_command: 1'b1, bus_value: CMD_ADDR_SET, last: 1'b0};
                n_buf[1] = '{is_command: 1'b0, bus_value: addr,         last: 1'b0};
                n_buf[2] = '{is_command: 1'b1, bus_value: CMD_RAM_DATA, last: 1'b1};
                n_cnt    = 2'd3;
                n_phase  = PH_AWAIT;
            end
            MODE_FB_BYTE: begin
                if (r_flip && r_mini) begin
                    case (r_phase)
                        PH_PRIMED: begin
                            n_pending = r_in_byte;
                            n_phase   = PH_PENDING;
                        end
                        PH_PENDING: begin
                            // window of three bytes, shifted right by a nibble
                            n_buf[0] = '{is_command: 1'b0,
                                         bus_value: {r_window[3:0], r_pending,
                                                     r_in_byte[7:4]},
                                         last: 1'b1};
                            n_cnt    = 2'd1;
                            n_window = r_in_byte;
                            n_phase  = PH_PRIMED;
                        end
                        default: begin
                            // prime the window, emit nothing
                            n_window = r_in_byte;
                            n_phase  = PH_PRIMED;
                        end
                    endcase
                end else if (r_phase == PH_PENDING) begin
                    n_buf[0] = '{is_command: 1'b0, bus_value: {r_pending, r_in_byte},
                                 last: 1'b1};
                    n_cnt    = 2'd1;
                    n_phase  = PH_AWAIT;
                end else begin
                    n_pending = r_in_byte;
                    n_phase   = PH_PENDING;
                end
            end
            MODE_MONO_BYTE: begin
                n_buf[0] = '{is_command: 1'b0,
                             bus_value: {dibit_double(r_in_byte[7:4]),
                                         dibit_double(r_in_byte[3:0])},
                             last: 1'b1};
                n_cnt    = 2'd1;
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip     <= 1'b0;
            r_mini     <= 1'b0;
            r_in_valid <= 1'b0;
            r_pending  <= '0;
            r_window   <= '0;
            r_phase    <= PH_AWAIT;
            r_left     <= 2'd0;
            r_pos      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FLIP) begin
                    r_flip <= i_cfg_data;
                end else if (i_cfg_index == CFG_MINI) begin
                    r_mini <= i_cfg_data;
                end
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_pending <= n_pending;
                r_window  <= n_window;
                r_phase   <= n_phase;
                r_left    <= n_cnt;
                r_pos     <= 2'd0;
            end else if (out_fire) begin
                r_left <= r_left - 2'd1;
                r_pos  <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode <= i_req.mode;
            r_in_row  <= i_req.row;
            r_in_col  <= i_req.column_word;
            r_in_byte <= i_req.data_byte;
        end
        if (move) begin
            r_buf[0] <= n_buf[0];
            r_buf[1] <= n_buf[1];
            r_buf[2] <= n_buf[2];
        end
    end

endmodule

// ===== rtl/lrwf_checker.sv =====
module lrwf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_is_command,
    input logic [15:0] i_bus_value,
    input logic        i_last
);
    import lrwf_pkg::*;

    // a stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_bus_value) && $stable(i_is_command) && $stable(i_last)))
        else $error("stalled transfer changed");

    // commands are only address-set (not last) or RAM data (last)
    a_cmd_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_command) |->
        ((i_bus_value == CMD_ADDR_SET && !i_last) || (i_bus_value == CMD_RAM_DATA && i_last)))
        else $error("bad command transfer");

    // address word follows address-set at once
    a_addr_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_is_command && i_bus_value == CMD_ADDR_SET) |=>
        (i_out_valid && !i_is_command && !i_last))
        else $error("address word missing after address-set");

    // reset drains the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // reset leaves the input register free for a request
    a_reset_ready_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("request side not ready after reset");

endmodule

bind lcd_row_write_formatter lrwf_checker u_lrwf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_is_command (o_res.is_command),
    .i_bus_value  (o_res.bus_value),
    .i_last       (o_res.last)
);

// ===== tb/lcd_row_write_formatter_test.sv =====
`timescale 1ns / 1ps

module lcd_row_write_formatter_test;
    import lrwf_pkg::*;

    localparam int COLUMNS      = 168;
    localparam int LAST_WORD    = COLUMNS / 8 - 1;
    localparam int SETTLE       = 6;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PER_SETTING  = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic {
        STEP_REQ,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        logic        cfg_index;
        logic        cfg_value;
        logic [1:0]  mode;
        logic [6:0]  row;
        logic [4:0]  column_word;
        logic [7:0]  data_byte;
        logic        typed;
        logic [15:0] typed_value;
    } t_step;

    // typed_value is the address word of a row start or the single data word of a byte
    localparam t_step DIRECTED [28] = '{
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd0,   5'd0,  8'h00, 1'b1, 16'h0014},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd127, 5'd31, 8'h00, 1'b1, 16'h0FD5},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd0,   5'd31, 8'h00, 1'b1, 16'hFFF5},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h00, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hFF, 1'b1, 16'h00FF},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_MONO_BYTE, 7'd0,   5'd0,  8'hFF, 1'b1, 16'hFFFF},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_MONO_BYTE, 7'd0,   5'd0,  8'h00, 1'b1, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hAB, 1'b0, 16'h0000},
        // mono byte between the two halves of a pair
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_MONO_BYTE, 7'd0,   5'd0,  8'hA5, 1'b1, 16'hCC33},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hCD, 1'b1, 16'hABCD},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_UNUSED,    7'd127, 5'd31, 8'h5A, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h12, 1'b0, 16'h0000},
        // row start drops the half pair
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd5,   5'd3,  8'h00, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h34, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h56, 1'b1, 16'h3456},
        '{STEP_CFG, CFG_FLIP, 1'b1, '0, '0, '0, '0, 1'b0, '0},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd127, 5'd0,  8'h00, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h80, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h01, 1'b1, 16'h8001},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h77, 1'b0, 16'h0000},
        // switch to the shifted window with a byte still pending
        '{STEP_CFG, CFG_MINI, 1'b1, '0, '0, '0, '0, 1'b0, '0},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h99, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_ROW_START, 7'd0,   5'd31, 8'h00, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hF0, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'h0F, 1'b0, 16'h0000},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hFF, 1'b0, 16'h0000},
        // back to plain pairing from a primed window
        '{STEP_CFG, CFG_FLIP, 1'b0, '0, '0, '0, '0, 1'b0, '0},
        '{STEP_REQ, CFG_FLIP, 1'b0, MODE_FB_BYTE,   7'd0,   5'd0,  8'hEE, 1'b0, 16'h0000}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic i_cfg_data;

    lrwf_in_if  req_if ();
    lrwf_out_if res_if ();

    lcd_row_write_formatter #(
        .PIXEL_COLUMNS(COLUMNS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // panel state as the block should hold it
    logic       cfg_flip;
    logic       cfg_mini;
    logic [7:0] pair_high;
    logic [7:0] window_low;
    t_phase     pair_phase;

    t_xfer bus_expect [$];

    int cycles;
    int failures;
    int burst_left;
    int n_rows;
    int n_fb;
    int n_mono;
    int n_ignored;
    int n_checked;
    int n_settings;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d transfers outstanding",
                     cycles, bus_expect.size());
            $display("lcd_row_write_formatter regression: fail");
            $finish;
        end
    end

    // sink stalls: none, light, heavy, then a fixed rhythm
    always @(negedge i_clk) begin
        case (cycles[8:7])
            2'd0: res_if.ready = 1'b1;
            2'd1: res_if.ready = ($urandom_range(0, 3) != 0);
            2'd2: res_if.ready = 1'($urandom_range(0, 1));
            default: res_if.ready = ((cycles % 7) > 2);
        endcase
    end

    function automatic void report_fail(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void expect_xfer(input logic cmd, input logic [15:0] val,
                                        input logic last);
        t_xfer x;
        x.is_command = cmd;
        x.bus_value  = val;
        x.last       = last;
        bus_expect.push_back(x);
    endfunction

    // work out the bus transfers caused by one accepted request
    function automatic void format_request(input t_step s);
        logic        emit;
        logic [15:0] val;
        logic [23:0] win;
        int          offset;
        int          addr;
        emit = 1'b0;
        val  = '0;
        case (s.mode)
            MODE_ROW_START: begin
                if (!cfg_flip)
                    offset = LAST_WORD;
                else if (cfg_mini)
                    offset = (22 << 5) + LAST_WORD - 4;
                else
                    offset = (4 << 5) + LAST_WORD - 1;
                addr = int'(s.row) * 32 + offset - int'(s.column_word);
                val = addr[15:0];
                pair_phase = PH_AWAIT;
                n_rows++;
            end
            MODE_FB_BYTE: begin
                n_fb++;
                if (cfg_flip && cfg_mini) begin
                    if (pair_phase == PH_PRIMED) begin
                        pair_high  = s.data_byte;
                        pair_phase = PH_PENDING;
                    end else if (pair_phase == PH_PENDING) begin
                        win  = {window_low, pair_high, s.data_byte};
                        val  = win[19:4];
                        emit = 1'b1;
                        window_low = s.data_byte;
                        pair_phase = PH_PRIMED;
                    end else begin
                        window_low = s.data_byte;
                        pair_phase = PH_PRIMED;
                    end
                end else if (pair_phase == PH_PENDING) begin
                    val  = {pair_high, s.data_byte};
                    emit = 1'b1;
                    pair_phase = PH_AWAIT;
                end else begin
                    pair_high  = s.data_byte;
                    pair_phase = PH_PENDING;
                end
            end
            MODE_MONO_BYTE: begin
                for (int i = 0; i < 8; i++)
                    val[2*i +: 2] = {2{s.data_byte[i]}};
                emit = 1'b1;
                n_mono++;
            end
            default: n_ignored++;
        endcase
        if (s.typed)
            val = s.typed_value;
        if (s.mode == MODE_ROW_START) begin
            expect_xfer(1'b1, CMD_ADDR_SET, 1'b0);
            expect_xfer(1'b0, val, 1'b0);
            expect_xfer(1'b1, CMD_RAM_DATA, 1'b1);
        end else if (emit) begin
            expect_xfer(1'b0, val, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (bus_expect.size() == 0) begin
                report_fail($sformatf("unexpected transfer cmd=%0d value=%04h last=%0d",
                                      res_if.is_command, res_if.bus_value, res_if.last));
            end else begin
                t_xfer want;
                want = bus_expect.pop_front();
                n_checked++;
                if (res_if.is_command !== want.is_command || res_if.bus_value !== want.bus_value
                    || res_if.last !== want.last)
                    report_fail($sformatf(
                        "expected cmd=%0d value=%04h last=%0d, got cmd=%0d value=%04h last=%0d",
                        want.is_command, want.bus_value, want.last,
                        res_if.is_command, res_if.bus_value, res_if.last));
            end
        end
    end

    // hold the source until every transfer has come, then let the last request settle
    task automatic drain_bus();
        int waited;
        waited = 0;
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (bus_expect.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic value);
        drain_bus();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_FLIP)
            cfg_flip = value;
        else
            cfg_mini = value;
    endtask

    task automatic send_request(input t_step s);
        @(negedge i_clk);
        req_if.valid       = 1'b1;
        req_if.mode        = s.mode;
        req_if.row         = s.row;
        req_if.column_word = s.column_word;
        req_if.data_byte   = s.data_byte;
        do @(posedge i_clk); while (!req_if.ready);
        format_request(s);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 6);
        end
    endtask

    function automatic t_step random_request(input logic [1:0] mode);
        t_step s;
        s.kind        = STEP_REQ;
        s.cfg_index   = CFG_FLIP;
        s.cfg_value   = 1'b0;
        s.mode        = mode;
        s.row         = 7'($urandom);
        s.column_word = 5'($urandom);
        s.data_byte   = 8'($urandom);
        s.typed       = 1'b0;
        s.typed_value = '0;
        return s;
    endfunction

    initial begin
        int    n;
        int    len;
        bit    paused;
        logic  flip_set;
        logic  mini_set;
        t_step s;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_FLIP;
        i_cfg_data         = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_ROW_START;
        req_if.row         = '0;
        req_if.column_word = '0;
        req_if.data_byte   = '0;
        failures   = 0;
        burst_left = 4;
        n_rows     = 0;
        n_fb       = 0;
        n_mono     = 0;
        n_ignored  = 0;
        n_checked  = 0;
        n_settings = 0;
        paused     = 1'b0;
        cfg_flip   = 1'b0;
        cfg_mini   = 1'b0;
        pair_high  = '0;
        window_low = '0;
        pair_phase = PH_AWAIT;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_CFG)
                write_reg(DIRECTED[i].cfg_index, DIRECTED[i].cfg_value);
            else
                send_request(DIRECTED[i]);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: {flip_set, mini_set} = 2'b00;
                1: {flip_set, mini_set} = 2'b11;
                2: {flip_set, mini_set} = 2'b10;
                3: {flip_set, mini_set} = 2'b01;
                default: {flip_set, mini_set} = 2'($urandom);
            endcase
            write_reg(CFG_FLIP, flip_set);
            write_reg(CFG_MINI, mini_set);
            n_settings++;
            n = 0;
            while (n < PER_SETTING) begin
                if (p == 2 && n >= PER_SETTING / 2 && !paused) begin
                    drain_bus();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) != 0) begin
                    // a row: start, then a run of pixel bytes with the odd mono byte
                    send_request(random_request(MODE_ROW_START));
                    n++;
                    len = $urandom_range(0, 12);
                    repeat (len) begin
                        send_request(random_request(($urandom_range(0, 9) == 0) ?
                                                    MODE_MONO_BYTE : MODE_FB_BYTE));
                        n++;
                    end
                end else begin
                    s = random_request(2'($urandom));
                    send_request(s);
                    if (s.mode != MODE_UNUSED)
                        n++;
                end
            end
        end

        drain_bus();
        if (bus_expect.size() != 0)
            report_fail($sformatf("%0d transfers never arrived", bus_expect.size()));

        $display("covered %0d row starts, %0d framebuffer bytes, %0d mono bytes, %0d ignored",
                 n_rows, n_fb, n_mono, n_ignored);
        $display("checked %0d bus transfers over %0d panel settings, %0d mismatches",
                 n_checked, n_settings, failures);
        if (failures == 0)
            $display("lcd_row_write_formatter regression: pass");
        else
            $display("lcd_row_write_formatter regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lrwf_pkg.sv
rtl/lrwf_in_if.sv
rtl/lrwf_out_if.sv
rtl/lcd_row_write_formatter.sv
rtl/lrwf_checker.sv
tb/lcd_row_write_formatter_test.sv
